// ===== hdl/lcs_pkg.sv =====
// shared constants, command and status types for the line centroid steering unit
package lcs_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int CFG_W          = 16;
   localparam int DIM_W          = 12;
   localparam int IDX_W          = 3;
   localparam int CNT_W          = 24;
   localparam int SUM_W          = 37;
   localparam int LIN_W          = 23;
   localparam int ANG_W          = 24;
   localparam int PROD_W         = 36;
   localparam int NUM_W          = 53;
   localparam int QUO_W          = 57;
   localparam int RATE_W         = 58;
   localparam int LINP_W         = 56;

   // shared arithmetic unit
   localparam int OPA_W      = 64;
   localparam int OPB_W      = 40;
   localparam int MUL_STEPS  = 24;
   localparam int DIV_STEPS  = 64;
   localparam int STEP_CNT_W = 7;

   // register indexes
   localparam logic [IDX_W-1:0] REG_GAIN_POSITION = 3'd0;
   localparam logic [IDX_W-1:0] REG_GAIN_DISTANCE = 3'd1;
   localparam logic [IDX_W-1:0] REG_CRUISE_SPEED  = 3'd2;
   localparam logic [IDX_W-1:0] REG_WHEEL_RADIUS  = 3'd3;
   localparam logic [IDX_W-1:0] REG_BAND_DIVISOR  = 3'd4;
   localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 3'd5;
   localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd6;

   // reset values
   localparam logic [CFG_W-1:0] RST_GAIN_POSITION = 16'd2586;
   localparam logic [CFG_W-1:0] RST_GAIN_DISTANCE = 16'd5146;
   localparam logic [CFG_W-1:0] RST_CRUISE_SPEED  = 16'd1229;
   localparam logic [CFG_W-1:0] RST_WHEEL_RADIUS  = 16'd5243;
   localparam logic [CFG_W-1:0] RST_BAND_DIVISOR  = 16'd8520;
   localparam logic [DIM_W-1:0] RST_FRAME_WIDTH   = 12'd640;
   localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT  = 12'd480;

   localparam logic [CFG_W-1:0] DIVISOR_MIN = 16'd4096;
   localparam logic [8:0]       DARK_LEVEL  = 9'd128;

   // gray weights
   localparam logic [13:0] W_RED   = 14'd4899;
   localparam logic [13:0] W_GREEN = 14'd9617;
   localparam logic [13:0] W_BLUE  = 14'd1868;
   localparam logic [22:0] GRAY_RND = 23'd8192;

   // datapath operation codes
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE = 4'd0;
   localparam logic [OP_W-1:0] OP_V1   = 4'd1;
   localparam logic [OP_W-1:0] OP_LO   = 4'd2;
   localparam logic [OP_W-1:0] OP_HI   = 4'd3;
   localparam logic [OP_W-1:0] OP_NUM1 = 4'd4;
   localparam logic [OP_W-1:0] OP_T1   = 4'd5;
   localparam logic [OP_W-1:0] OP_DEN2 = 4'd6;
   localparam logic [OP_W-1:0] OP_NUM2 = 4'd7;
   localparam logic [OP_W-1:0] OP_T2   = 4'd8;
   localparam logic [OP_W-1:0] OP_LIN  = 4'd9;

   typedef struct packed {
      logic            acc_en;
      logic            snap;
      logic            start;
      logic            latch;
      logic [OP_W-1:0] op;
      logic            load_rsp;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic n_zero;
      logic in_band;
      logic v1_zero;
      logic h_zero;
   } status_type;

endpackage

// ===== hdl/lcs_arith.sv =====
// shared shift-add multiplier and restoring divider, one bit per cycle
module lcs_arith
   import lcs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             is_div,
   input  logic [OPA_W-1:0] opa,
   input  logic [OPB_W-1:0] opb,
   output logic [OPA_W-1:0] result,
   output logic             done
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  mode_ff, mode_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [OPA_W-1:0]      x_ff, x_in;
   logic [OPB_W-1:0]      y_ff, y_in;
   logic [OPA_W-1:0]      acc_ff, acc_in;
   logic [OPB_W:0]        trial;
   logic [OPB_W:0]        rem;
   logic                  ge;

   assign trial = {acc_ff[OPB_W-1:0], x_ff[OPA_W-1]};
   assign ge    = trial >= {1'b0, y_ff};
   assign rem   = ge ? trial - {1'b0, y_ff} : trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         mode_in = is_div;
         cnt_in  = is_div ? STEP_CNT_W'(DIV_STEPS - 1) : STEP_CNT_W'(MUL_STEPS - 1);
         x_in    = opa;
         y_in    = opb;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (mode_ff) begin
            acc_in = {{(OPA_W-OPB_W-1){1'b0}}, rem};
            x_in   = {x_ff[OPA_W-2:0], ge};
         end else begin
            if (y_ff[0]) begin
               acc_in = acc_ff + x_ff;
            end
            x_in = {x_ff[OPA_W-2:0], 1'b0};
            y_in = {1'b0, y_ff[OPB_W-1:1]};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
   end

   assign result = mode_ff ? x_ff : acc_ff;
   assign done   = done_ff;

endmodule

// ===== hdl/lcs_datapath.sv =====
// datapath: config registers, pixel accumulators, frame-end operands and result register
module lcs_datapath
   import lcs_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [7:0]              req_blue,
   input  logic [7:0]              req_green,
   input  logic [7:0]              req_red,
   input  logic                    csr_write_en,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]        csr_write_data,
   output logic [LIN_W-1:0]        rsp_linear_speed,
   output logic signed [ANG_W-1:0] rsp_angular_rate,
   output logic                    rsp_line_found
);

   localparam int CMP_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

   // configuration
   logic [CFG_W-1:0] gain_pos_ff, gain_dist_ff, cruise_ff, wheel_ff, band_div_ff;
   logic [DIM_W-1:0] width_ff, height_ff;

   // frame accumulators
   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SUM_W-1:0]      csum_ff, csum_in, rsum_ff, rsum_in;

   // frame-end work registers
   logic [CNT_W-1:0]  n_ff;
   logic [SUM_W-1:0]  cs_ff, rs_ff;
   logic [DIM_W-1:0]  v1_ff;
   logic [PROD_W-1:0] lo_ff, hi_ff, den_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [QUO_W-1:0]  t1_ff, t2_ff;
   logic [LINP_W-1:0] prod_ff;

   logic [LIN_W-1:0]  lin_out_ff;
   logic [ANG_W-1:0]  ang_out_ff;
   logic              found_out_ff;

   logic [22:0]      gray_sum;
   logic             dark;
   logic [DIM_W-1:0] wlim_m1;
   logic             wrap;
   logic [SUM_W:0]   csum_add, rsum_add;

   logic [CFG_W-1:0] divc;
   logic             left;
   logic [SUM_W-1:0] diff;
   logic [RATE_W-1:0] rate;
   logic [OPB_W-1:0]  rate_c;
   logic [OPB_W-1:0]  lin_full;
   logic [LIN_W-1:0]  lin_sat;
   logic [ANG_W-1:0]  ang_pos;
   logic [ANG_W:0]    ang_mag;
   logic [ANG_W-1:0]  ang_val;

   logic [OPA_W-1:0] opa;
   logic [OPB_W-1:0] opb;
   logic             is_div;
   logic [OPA_W-1:0] arith_result;
   logic             arith_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_pos_ff  <= RST_GAIN_POSITION;
         gain_dist_ff <= RST_GAIN_DISTANCE;
         cruise_ff    <= RST_CRUISE_SPEED;
         wheel_ff     <= RST_WHEEL_RADIUS;
         band_div_ff  <= RST_BAND_DIVISOR;
         width_ff     <= RST_FRAME_WIDTH;
         height_ff    <= RST_FRAME_HEIGHT;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_GAIN_POSITION: gain_pos_ff  <= csr_write_data;
            REG_GAIN_DISTANCE: gain_dist_ff <= csr_write_data;
            REG_CRUISE_SPEED:  cruise_ff    <= csr_write_data;
            REG_WHEEL_RADIUS:  wheel_ff     <= csr_write_data;
            REG_BAND_DIVISOR:  band_div_ff  <= csr_write_data;
            REG_FRAME_WIDTH:   width_ff     <= csr_write_data[DIM_W-1:0];
            REG_FRAME_HEIGHT:  height_ff    <= csr_write_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // pixel accumulation
   assign gray_sum = 23'(req_red * W_RED) + 23'(req_green * W_GREEN)
                   + 23'(req_blue * W_BLUE) + GRAY_RND;
   assign dark     = gray_sum[22:14] <= DARK_LEVEL;
   assign wlim_m1  = (width_ff == '0) ? '0 : width_ff - 1'b1;
   assign wrap     = CMP_W'(col_ff) >= CMP_W'(wlim_m1);
   assign csum_add = {1'b0, csum_ff} + (SUM_W+1)'(col_ff);
   assign rsum_add = {1'b0, rsum_ff} + (SUM_W+1)'(row_ff);

   always_comb begin
      cnt_in  = cnt_ff;
      csum_in = csum_ff;
      rsum_in = rsum_ff;
      if (dark && (cnt_ff != '1)) begin
         cnt_in  = cnt_ff + 1'b1;
         csum_in = csum_add[SUM_W] ? '1 : csum_add[SUM_W-1:0];
         rsum_in = rsum_add[SUM_W] ? '1 : rsum_add[SUM_W-1:0];
      end
      if (wrap) begin
         col_in = '0;
         row_in = row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         cnt_ff  <= '0;
         csum_ff <= '0;
         rsum_ff <= '0;
      end else if (cmd.acc_en) begin
         if (cmd.snap) begin
            col_ff  <= '0;
            row_ff  <= '0;
            cnt_ff  <= '0;
            csum_ff <= '0;
            rsum_ff <= '0;
         end else begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            cnt_ff  <= cnt_in;
            csum_ff <= csum_in;
            rsum_ff <= rsum_in;
         end
      end
   end

   // frame-end operands
   assign divc = (band_div_ff < DIVISOR_MIN) ? DIVISOR_MIN : band_div_ff;
   assign left = cs_ff < {1'b0, lo_ff};
   assign diff = left ? {1'b0, lo_ff} - cs_ff : cs_ff - {1'b0, hi_ff};
   assign rate = {1'b0, t1_ff} + {1'b0, t2_ff};
   assign rate_c = (|rate[RATE_W-1:OPB_W]) ? '1 : rate[OPB_W-1:0];

   always_comb begin
      opa    = '0;
      opb    = '0;
      is_div = 1'b0;
      unique case (cmd.op)
         OP_V1: begin
            opa    = OPA_W'({width_ff, 12'd0});
            opb    = OPB_W'(divc);
            is_div = 1'b1;
         end
         OP_LO: begin
            opa = OPA_W'(n_ff);
            opb = OPB_W'(v1_ff);
         end
         OP_HI: begin
            opa = OPA_W'(n_ff);
            opb = OPB_W'(width_ff - v1_ff);
         end
         OP_NUM1: begin
            opa = OPA_W'(diff);
            opb = OPB_W'(gain_pos_ff);
         end
         OP_T1: begin
            opa    = OPA_W'({num_ff, 4'd0});
            opb    = OPB_W'(lo_ff);
            is_div = 1'b1;
         end
         OP_DEN2: begin
            opa = OPA_W'(n_ff);
            opb = OPB_W'(height_ff);
         end
         OP_NUM2: begin
            opa = OPA_W'(rs_ff);
            opb = OPB_W'(gain_dist_ff);
         end
         OP_T2: begin
            opa    = OPA_W'({num_ff, 4'd0});
            opb    = OPB_W'(den_ff);
            is_div = 1'b1;
         end
         OP_LIN: begin
            opa = OPA_W'(rate_c);
            opb = OPB_W'(wheel_ff);
         end
         default: ;
      endcase
   end

   lcs_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start),
      .is_div (is_div),
      .opa    (opa),
      .opb    (opb),
      .result (arith_result),
      .done   (arith_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         n_ff  <= cnt_in;
         cs_ff <= csum_in;
         rs_ff <= rsum_in;
         t1_ff <= '0;
         t2_ff <= '0;
      end else if (cmd.latch) begin
         case (cmd.op)
            OP_V1:   v1_ff   <= arith_result[DIM_W-1:0];
            OP_LO:   lo_ff   <= arith_result[PROD_W-1:0];
            OP_HI:   hi_ff   <= arith_result[PROD_W-1:0];
            OP_NUM1: num_ff  <= arith_result[NUM_W-1:0];
            OP_T1:   t1_ff   <= arith_result[QUO_W-1:0];
            OP_DEN2: den_ff  <= arith_result[PROD_W-1:0];
            OP_NUM2: num_ff  <= arith_result[NUM_W-1:0];
            OP_T2:   t2_ff   <= arith_result[QUO_W-1:0];
            OP_LIN:  prod_ff <= arith_result[LINP_W-1:0];
            default: ;
         endcase
      end
   end

   assign status.done    = arith_done;
   assign status.n_zero  = n_ff == '0;
   assign status.in_band = (cs_ff >= {1'b0, lo_ff}) && (cs_ff <= {1'b0, hi_ff});
   assign status.v1_zero = v1_ff == '0;
   assign status.h_zero  = height_ff == '0;

   // result shaping and saturation
   assign lin_full = prod_ff[LINP_W-1:16];
   assign lin_sat  = (|lin_full[OPB_W-1:LIN_W]) ? '1 : lin_full[LIN_W-1:0];
   assign ang_pos  = (rate > RATE_W'(24'h7FFFFF)) ? 24'h7FFFFF : rate[ANG_W-1:0];
   assign ang_mag  = (rate > RATE_W'(25'h800000)) ? 25'h800000 : rate[ANG_W:0];
   assign ang_val  = left ? ang_pos : ANG_W'(25'd0 - ang_mag);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (status.n_zero) begin
            lin_out_ff   <= '0;
            ang_out_ff   <= '0;
            found_out_ff <= 1'b0;
         end else if (status.in_band) begin
            lin_out_ff   <= LIN_W'(cruise_ff);
            ang_out_ff   <= '0;
            found_out_ff <= 1'b1;
         end else begin
            lin_out_ff   <= lin_sat;
            ang_out_ff   <= ang_val;
            found_out_ff <= 1'b1;
         end
      end
   end

   assign rsp_linear_speed = lin_out_ff;
   assign rsp_angular_rate = $signed(ang_out_ff);
   assign rsp_line_found   = found_out_ff;

endmodule

// ===== hdl/lcs_ctrl.sv =====
// controller: pixel streaming, frame-end operation sequence and result handshake
module lcs_ctrl
   import lcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_end_of_frame,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [3:0] S_RUN  = 4'd0;
   localparam logic [3:0] S_V1   = 4'd1;
   localparam logic [3:0] S_LO   = 4'd2;
   localparam logic [3:0] S_HI   = 4'd3;
   localparam logic [3:0] S_CMP  = 4'd4;
   localparam logic [3:0] S_NUM1 = 4'd5;
   localparam logic [3:0] S_T1   = 4'd6;
   localparam logic [3:0] S_DEN2 = 4'd7;
   localparam logic [3:0] S_NUM2 = 4'd8;
   localparam logic [3:0] S_T2   = 4'd9;
   localparam logic [3:0] S_LIN  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       launched_ff, launched_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       comp;
   logic       skip;
   logic [3:0] nxt;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      launched_in  = launched_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = state_ff != S_RUN;
      comp         = 1'b0;
      skip         = 1'b0;
      nxt          = state_ff;
      unique case (state_ff)
         S_RUN: begin
            if (req_valid) begin
               cmd.acc_en = 1'b1;
               if (req_end_of_frame) begin
                  cmd.snap = 1'b1;
                  state_in = S_V1;
               end
            end
         end
         S_V1: begin
            comp = 1'b1; cmd.op = OP_V1; nxt = S_LO;
         end
         S_LO: begin
            comp = 1'b1; cmd.op = OP_LO; nxt = S_HI;
         end
         S_HI: begin
            comp = 1'b1; cmd.op = OP_HI; nxt = S_CMP;
         end
         S_CMP: begin
            state_in = (status.n_zero || status.in_band) ? S_OUT : S_NUM1;
         end
         S_NUM1: begin
            comp = 1'b1; cmd.op = OP_NUM1; nxt = S_T1;
         end
         S_T1: begin
            // no horizontal term when the band edge is zero
            comp = 1'b1; cmd.op = OP_T1; nxt = S_DEN2; skip = status.v1_zero;
         end
         S_DEN2: begin
            comp = 1'b1; cmd.op = OP_DEN2; nxt = S_NUM2;
         end
         S_NUM2: begin
            comp = 1'b1; cmd.op = OP_NUM2; nxt = S_T2;
         end
         S_T2: begin
            comp = 1'b1; cmd.op = OP_T2; nxt = S_LIN; skip = status.h_zero;
         end
         S_LIN: begin
            comp = 1'b1; cmd.op = OP_LIN; nxt = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_RUN;
            end
         end
         default: state_in = S_RUN;
      endcase

      if (comp) begin
         if (skip) begin
            state_in = nxt;
         end else if (!launched_ff) begin
            cmd.start   = 1'b1;
            launched_in = 1'b1;
         end else if (status.done) begin
            cmd.latch   = 1'b1;
            launched_in = 1'b0;
            state_in    = nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/line_centroid_steering_unit.sv =====
// top level of the line centroid steering unit
// Pixels stream in at one item per clock while req_stall is low; every dark pixel updates
// the dark-pixel count and the column and row sums. The pixel flagged end_of_frame starts
// the steering computation, which runs through one shared bit-serial unit and holds
// req_stall high for its sequence: band edge divide, two band-limit products, then on the
// proportional path two numerator products, the row denominator product, two quotient
// divides and the wheel radius product. Inside the band or with no dark pixels the sequence
// ends after the band limits. The result waits in an output register, and pixels of the
// next frame are accepted while it is pending.
module line_centroid_steering_unit
   import lcs_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_blue,
   input  logic [7:0]              req_green,
   input  logic [7:0]              req_red,
   input  logic                    req_end_of_frame,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [LIN_W-1:0]        rsp_linear_speed,
   output logic signed [ANG_W-1:0] rsp_angular_rate,
   output logic                    rsp_line_found,
   input  logic                    csr_write_en,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]        csr_write_data
);

   cmd_type    cmd;
   status_type status;

   lcs_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_end_of_frame (req_end_of_frame),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .status           (status)
   );

   lcs_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_blue         (req_blue),
      .req_green        (req_green),
      .req_red          (req_red),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_angular_rate (rsp_angular_rate),
      .rsp_line_found   (rsp_line_found)
   );

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench for the line centroid steering unit
module tb_top
   import lcs_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 450;

   typedef struct packed {
      logic [LIN_W-1:0] lin;
      logic [ANG_W-1:0] ang;
      logic             found;
   } steer_cmd_type;

   // predicts the steering command of each frame and checks the block against it
   class steering_predictor;
      int unsigned gain_pos, gain_dist, cruise, wheel, divisor, width, height;
      logic [11:0] col, row;
      int unsigned dark_n;
      longint unsigned col_sum, row_sum;
      steer_cmd_type expected_cmds[$];
      int errors, checked, n_empty, n_inside, n_left, n_right;

      function void reset_state();
         gain_pos = RST_GAIN_POSITION; gain_dist = RST_GAIN_DISTANCE;
         cruise = RST_CRUISE_SPEED; wheel = RST_WHEEL_RADIUS;
         divisor = RST_BAND_DIVISOR; width = RST_FRAME_WIDTH; height = RST_FRAME_HEIGHT;
         clear_frame();
      endfunction

      function void clear_frame();
         col = 0; row = 0; dark_n = 0; col_sum = 0; row_sum = 0;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
         case (idx)
            REG_GAIN_POSITION: gain_pos = d;
            REG_GAIN_DISTANCE: gain_dist = d;
            REG_CRUISE_SPEED:  cruise = d;
            REG_WHEEL_RADIUS:  wheel = d;
            REG_BAND_DIVISOR:  divisor = d;
            REG_FRAME_WIDTH:   width = d[DIM_W-1:0];
            REG_FRAME_HEIGHT:  height = d[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic eof);
         int unsigned gray, wlim;
         longint unsigned n, v1, v2, lo, hi, dv, diff, t1, t2, rate, lin, mag;
         logic left;
         steer_cmd_type c;
         gray = (r * 4899 + g * 9617 + b * 1868 + 8192) >> 14;
         wlim = (width != 0) ? width : 1;
         if (gray <= 128 && dark_n < 24'hFFFFFF) begin
            dark_n++;
            col_sum += col;
            if (col_sum > 64'h1F_FFFF_FFFF) col_sum = 64'h1F_FFFF_FFFF;
            row_sum += row;
            if (row_sum > 64'h1F_FFFF_FFFF) row_sum = 64'h1F_FFFF_FFFF;
         end
         if (col >= wlim - 1) begin
            col = 0;
            row = row + 1;
         end else begin
            col = col + 1;
         end
         if (!eof) return;
         c = '0;
         if (dark_n == 0) begin
            n_empty++;
         end else begin
            n = dark_n;
            dv = (divisor < 4096) ? 4096 : divisor;
            v1 = (longint'(width) * 4096) / dv;
            v2 = width - v1;
            lo = v1 * n;
            hi = v2 * n;
            c.found = 1'b1;
            if (col_sum >= lo && col_sum <= hi) begin
               c.lin = LIN_W'(cruise);
               n_inside++;
            end else begin
               left = col_sum < lo;
               diff = left ? lo - col_sum : col_sum - hi;
               t1 = (v1 != 0) ? (longint'(gain_pos) * 16 * diff) / (v1 * n) : 0;
               t2 = (height != 0) ? (longint'(gain_dist) * 16 * row_sum) / (n * height) : 0;
               rate = t1 + t2;
               lin = (rate * wheel) >> 16;
               c.lin = (lin > 8388607) ? 23'h7FFFFF : lin[LIN_W-1:0];
               if (left) begin
                  c.ang = (rate > 8388607) ? 24'h7FFFFF : rate[ANG_W-1:0];
                  n_left++;
               end else begin
                  mag = (rate > 8388608) ? 8388608 : rate;
                  c.ang = 24'(0 - mag);
                  n_right++;
               end
            end
         end
         expected_cmds.push_back(c);
         clear_frame();
      endfunction

      function void check_command(steer_cmd_type got);
         steer_cmd_type e;
         checked++;
         if (expected_cmds.size() == 0) begin
            errors++;
            $display("%0t: unexpected command lin=%0d ang=%0d found=%0d", $time,
                     got.lin, $signed(got.ang), got.found);
            return;
         end
         e = expected_cmds.pop_front();
         if (got.lin !== e.lin) begin
            errors++;
            $display("%0t: linear_speed expected %0d got %0d", $time, e.lin, got.lin);
         end
         if (got.ang !== e.ang) begin
            errors++;
            $display("%0t: angular_rate expected %0d got %0d", $time,
                     $signed(e.ang), $signed(got.ang));
         end
         if (got.found !== e.found) begin
            errors++;
            $display("%0t: line_found expected %0d got %0d", $time, e.found, got.found);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic [7:0] req_blue = '0, req_green = '0, req_red = '0;
   logic req_end_of_frame = 1'b0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic [LIN_W-1:0] rsp_linear_speed;
   logic signed [ANG_W-1:0] rsp_angular_rate;
   logic rsp_line_found;
   logic csr_write_en = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_write_data = '0;

   steering_predictor pred = new();
   int hold_off = 0;
   bit calm = 0;
   int idle_cycles = 0;
   int pixels_sent = 0;
   int frames_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   line_centroid_steering_unit u_dut (.*);

   // result side: accept and check at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         pred.check_command({rsp_linear_speed, rsp_angular_rate, rsp_line_found});
   end

   // receiver stall pattern, with the long hold-off when asked
   int stall_run = 0;
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off--;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin rsp_stall <= 1'b0; stall_run = $urandom_range(0, 8); end
            6, 7, 8: begin rsp_stall <= 1'b1; stall_run = $urandom_range(0, 3); end
            default: begin rsp_stall <= 1'b1; stall_run = $urandom_range(10, 60); end
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, %0d commands still expected", $time,
                  pred.expected_cmds.size());
         $display("** line_centroid_steering_unit: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= d;
      pred.write_reg(idx, d);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(int gp, int gd, int cs, int wr, int bd, int fw, int fh);
      write_reg(REG_GAIN_POSITION, gp);
      write_reg(REG_GAIN_DISTANCE, gd);
      write_reg(REG_CRUISE_SPEED, cs);
      write_reg(REG_WHEEL_RADIUS, wr);
      write_reg(REG_BAND_DIVISOR, bd);
      write_reg(REG_FRAME_WIDTH, fw);
      write_reg(REG_FRAME_HEIGHT, fh);
   endtask

   // offers one pixel at the falling edge and holds it until accepted
   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic eof);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_blue <= b;
      req_green <= g;
      req_red <= r;
      req_end_of_frame <= eof;
      do @(posedge clock); while (req_stall);
      pred.take_pixel(b, g, r, eof);
      pixels_sent++;
      if (eof) frames_sent++;
      if (calm) gap = 0;
      else case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
         5: gap = $urandom_range(10, 40);
         default: gap = 0;
      endcase
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop offering items, then wait for every expected command
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pred.expected_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one frame with a line pattern chosen at random
   task automatic send_frame(int len);
      int mode, c0, c1, wl, c;
      logic dark;
      logic [7:0] b, g, r;
      wl = (pred.width != 0) ? pred.width : 1;
      mode = $urandom_range(0, 9);
      c0 = $urandom_range(0, wl - 1);
      c1 = $urandom_range(c0, (c0 + 3 < wl) ? c0 + 3 : wl - 1);
      c = 0;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0, 1: dark = $urandom_range(0, 1);
            2: dark = 0;
            3: dark = 1;
            default: dark = (c >= c0 && c <= c1) ^ ($urandom_range(0, 15) == 0);
         endcase
         if (mode == 0) begin
            b = $urandom; g = $urandom; r = $urandom;
         end else if (dark) begin
            b = $urandom_range(0, 255); g = $urandom_range(0, 60); r = $urandom_range(0, 120);
         end else begin
            b = $urandom_range(0, 255); g = $urandom_range(200, 255); r = $urandom_range(100, 255);
         end
         send_pixel(b, g, r, i == len - 1);
         c = (c >= wl - 1) ? 0 : c + 1;
      end
   endtask

   task automatic run_frames(int n_pixels, int max_len);
      int sent, len;
      sent = 0;
      while (sent < n_pixels) begin
         len = $urandom_range(1, max_len);
         send_frame(len);
         sent += len;
      end
   endtask

   initial begin
      pred.reset_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default registers, color extremes and the dark threshold
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);            // frame with no dark pixel
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b0);            // gray exactly at threshold
      send_pixel(8'd129, 8'd129, 8'd129, 1'b0);            // just above
      send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b1);                // left of the band
      for (int i = 0; i < 8; i++)
         send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      drain();

      // small frame, left, right and inside
      configure(2586, 5146, 1229, 5243, 8520, 8, 6);
      calm = 1;
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 8; i++)
            send_pixel(8'd255, (i == k * 3 + 1) ? 8'd0 : 8'd255, 8'd255, i == 7);
      calm = 0;
      run_frames(200, 40);
      drain();

      // extremes: full gains and speeds, narrowest frame, divisor at one
      configure(65535, 65535, 65535, 65535, 4096, 1, 1);
      run_frames(120, 12);
      drain();

      // zero gains, tallest frame, band edge rounds down to one
      configure(0, 0, 0, 0, 65535, 16, 4095);
      run_frames(120, 30);
      drain();

      // zero width and height, divisor below one
      configure(40000, 300, 777, 60000, 0, 0, 0);
      run_frames(80, 10);
      drain();

      // widest frame with divisor just below one: band collapses to the right edge
      configure(65535, 65535, 100, 65535, 4095, 4095, 7);
      run_frames(120, 60);
      drain();

      // receiver holds off while results wait and pixels stall
      configure(3000, 5000, 1229, 5243, 8520, 4, 3);
      hold_off = 1500;
      run_frames(150, 6);
      drain();

      // random settings
      for (int p = 0; p < 6; p++) begin
         configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(4096, 65535), $urandom_range(1, 24),
                   $urandom_range(1, 4095));
         calm = (p == 2);
         run_frames(120, 50);
         calm = 0;
         drain();
      end

      $display("covered %0d pixels in %0d frames, %0d commands checked", pixels_sent,
               frames_sent, pred.checked);
      $display("commands: %0d no line, %0d inside band, %0d turn left, %0d turn right",
               pred.n_empty, pred.n_inside, pred.n_left, pred.n_right);
      if (pred.errors == 0 && pred.expected_cmds.size() == 0)
         $display("** line_centroid_steering_unit: PASSED **");
      else
         $display("** line_centroid_steering_unit: FAILED **");
      $finish;
   end

endmodule
